// File: design/rhp_pkg.sv
package rhp_pkg;

    localparam int DEPTH_W   = 16;
    localparam int REGION_W  = 4;
    localparam int BINS_W    = 9;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int OUTCOME_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DIST = 3'd0,
        CFG_MAX_DIST = 3'd1,
        CFG_BINS     = 3'd2,
        CFG_THRESH   = 3'd3,
        CFG_IGNORE   = 3'd4
    } cfg_idx_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTC_FOUND = 2'd0,
        OUTC_FEW   = 2'd1,
        OUTC_KEPT  = 2'd2
    } outcome_t;

    // live configuration, bins already clamped to the usable range
    typedef struct packed {
        logic [DEPTH_W-1:0] min_dist;
        logic [DEPTH_W-1:0] max_dist;
        logic [BINS_W-1:0]  bin_num;
        logic [FRAC_W-1:0]  thresh;
        logic [FRAC_W-1:0]  ignore;
    } cfg_t;

    // classified pixel held in the queue
    typedef struct packed {
        logic [DEPTH_W-1:0]  offset;
        logic [REGION_W-1:0] region;
        logic                counted;
        logic                valid;
        logic                binned;
        logic                frame_end;
    } pix_t;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_stat_t;

endpackage

// File: design/region_histogram_percentile_depth_unit.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// pixel     in         in_valid / in_ready    depth, region, frame_end
// result    out        out_valid / out_ready  region_index, region_depth, outcome, last
//
// A pixel outside the histogram range leaves the back end straight from idle; a binned pixel
// waits on the bit-serial divider for its bin before its count is read and written back.
// Frame end walks every region, reading each bin through the single histogram memory port
// and waiting on the divider when a percentile is found; output stalls hold the walk.
// After reset all 2^(region bits + bin bits) histogram entries (4096 by default) are swept
// to zero; pixels are not taken meanwhile. A two-entry queue takes pixels while
// the back end is busy or a result waits.
module region_histogram_percentile_depth_unit import rhp_pkg::*; #(
    parameter int REGION_COLUMNS = 5,
    parameter int REGION_ROWS    = 3,
    parameter int MAX_BINS       = 256,
    parameter int COUNT_BITS     = 19
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DEPTH_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DEPTH_W-1:0]   depth,
    input  logic [REGION_W-1:0]  region,
    input  logic                 frame_end,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [REGION_W-1:0]  region_index,
    output logic [DEPTH_W-1:0]   region_depth,
    output logic [OUTCOME_W-1:0] outcome,
    output logic                 last
);

    localparam int NUM_REGIONS = REGION_COLUMNS * REGION_ROWS;

    logic [DEPTH_W-1:0] min_reg;
    logic [DEPTH_W-1:0] max_reg;
    logic [BINS_W-1:0]  bins_reg;
    logic [FRAC_W-1:0]  thr_reg;
    logic [FRAC_W-1:0]  ign_reg;
    cfg_t               cfg;
    back_stat_t         stat;
    pix_t               head;
    logic               head_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= '0;
            max_reg  <= '1;
            bins_reg <= BINS_W'(64);
            thr_reg  <= '0;
            ign_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_DIST: min_reg  <= cfg_data;
                CFG_MAX_DIST: max_reg  <= cfg_data;
                CFG_BINS:     bins_reg <= cfg_data[BINS_W-1:0];
                CFG_THRESH:   thr_reg  <= cfg_data;
                CFG_IGNORE:   ign_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.min_dist = min_reg;
        cfg.max_dist = max_reg;
        cfg.thresh   = thr_reg;
        cfg.ignore   = ign_reg;
        if (bins_reg == '0)
        begin
            cfg.bin_num = BINS_W'(1);
        end
        else if (32'(bins_reg) > MAX_BINS)
        begin
            cfg.bin_num = BINS_W'(MAX_BINS);
        end
        else
        begin
            cfg.bin_num = bins_reg;
        end
    end

    rhp_front #(
        .NUM_REGIONS (NUM_REGIONS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .depth      (depth),
        .region     (region),
        .frame_end  (frame_end),
        .cfg        (cfg),
        .stat       (stat),
        .head       (head),
        .head_valid (head_valid)
    );

    rhp_back #(
        .NUM_REGIONS (NUM_REGIONS),
        .MAX_BINS    (MAX_BINS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .head_valid   (head_valid),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .region_index (region_index),
        .region_depth (region_depth),
        .outcome      (outcome),
        .last         (last)
    );

    a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        stat.init_busy |-> !in_ready)
        else $error("pixel taken during memory clear");

    a_last_is_final_region: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> region_index == REGION_W'(NUM_REGIONS - 1))
        else $error("last flag on wrong region");

    a_few_reports_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome == OUTC_FEW |-> region_depth == max_reg)
        else $error("too-few outcome without max distance");

    a_found_above_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome == OUTC_FOUND |-> region_depth >= min_reg)
        else $error("percentile depth below min distance");

endmodule

// File: design/rhp_div.sv
module rhp_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] nq_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    // one restoring step per cycle: numerator bits shift out, quotient bits shift in
    always_comb
    begin
        trial = {rem_reg, nq_reg[NUM_W-1]};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            nq_reg  <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            nq_reg  <= {nq_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

// File: design/rhp_front.sv
module rhp_front import rhp_pkg::*; #(
    parameter int NUM_REGIONS = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [DEPTH_W-1:0]  depth,
    input  logic [REGION_W-1:0] region,
    input  logic                frame_end,
    input  cfg_t                cfg,
    input  back_stat_t          stat,
    output pix_t                head,
    output logic                head_valid
);

    pix_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    pix_t       item;
    logic       push;

    always_comb
    begin
        item.offset    = depth - cfg.min_dist;
        item.region    = region;
        item.counted   = 32'(region) < NUM_REGIONS;
        item.valid     = item.counted && depth >= cfg.min_dist && depth <= cfg.max_dist;
        item.binned    = item.counted && depth >= cfg.min_dist && depth < cfg.max_dist;
        item.frame_end = frame_end;
    end

    assign in_ready   = fill_reg != 2'd2 && !stat.init_busy;
    assign push       = in_valid && in_ready;
    assign head_valid = fill_reg != 2'd0;
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (stat.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !stat.pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (!push && stat.pop)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// File: design/rhp_back.sv
module rhp_back import rhp_pkg::*; #(
    parameter int NUM_REGIONS = 15,
    parameter int MAX_BINS    = 256,
    parameter int COUNT_BITS  = 19
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  pix_t                 head,
    input  logic                 head_valid,
    output back_stat_t           stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [REGION_W-1:0]  region_index,
    output logic [DEPTH_W-1:0]   region_depth,
    output logic [OUTCOME_W-1:0] outcome,
    output logic                 last
);

    localparam int LOOP_W    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int BIDX_W    = $clog2(MAX_BINS);
    localparam int AW        = LOOP_W + BIDX_W;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int MW        = (BIDX_W > BINS_W) ? BIDX_W : BINS_W;
    localparam int NUM_W     = DEPTH_W + MW;
    localparam int CUM_W     = COUNT_BITS + BIDX_W;
    localparam int PROD_W    = COUNT_BITS + FRAC_W;
    localparam int CMP_W     = CUM_W + FRAC_W;
    localparam int KC_W      = MW + 1;

    typedef enum logic [14:0] {
        ST_INIT  = 15'b000000000000001,
        ST_IDLE  = 15'b000000000000010,
        ST_PMUL  = 15'b000000000000100,
        ST_PDIV  = 15'b000000000001000,
        ST_PWAIT = 15'b000000000010000,
        ST_PRD   = 15'b000000000100000,
        ST_PWR   = 15'b000000001000000,
        ST_REG   = 15'b000000010000000,
        ST_CMP   = 15'b000000100000000,
        ST_WALK  = 15'b000001000000000,
        ST_WTAIL = 15'b000010000000000,
        ST_DMUL  = 15'b000100000000000,
        ST_DDIV  = 15'b001000000000000,
        ST_DWAIT = 15'b010000000000000,
        ST_OUT   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]         sweep_reg;
    pix_t                  pix_reg;
    logic [BIDX_W-1:0]     bin_reg;
    logic [LOOP_W-1:0]     walk_reg;
    logic [BIDX_W-1:0]     k_reg;
    logic                  rd_valid_reg;
    logic [BIDX_W-1:0]     rd_k_reg;
    logic [CUM_W-1:0]      cum_reg;
    logic                  found_reg;
    logic [BIDX_W-1:0]     fk_reg;
    logic [PROD_W-1:0]     thr_prod_reg;
    logic [PROD_W-1:0]     lim_reg;
    logic                  few_reg;
    logic [NUM_W-1:0]      mul_reg;
    logic [COUNT_BITS-1:0] pix_cnt_reg  [NUM_REGIONS];
    logic [COUNT_BITS-1:0] val_cnt_reg  [NUM_REGIONS];
    logic [DEPTH_W-1:0]    last_dep_reg [NUM_REGIONS];

    logic                  out_valid_reg;
    logic [REGION_W-1:0]   idx_reg;
    logic [DEPTH_W-1:0]    depth_reg;
    outcome_t              outc_reg;
    logic                  last_reg;

    logic [COUNT_BITS-1:0] mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] mem_rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [COUNT_BITS-1:0] mem_wdata;

    logic                  pop;
    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [DEPTH_W-1:0]    div_den;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quo;

    logic [LOOP_W-1:0]     hidx;
    logic [LOOP_W-1:0]     pidx;
    logic [DEPTH_W-1:0]    span;
    logic [CUM_W-1:0]      cum_next;
    logic                  bin_live;
    logic                  hit;
    logic                  out_load;
    logic                  last_region;
    logic [DEPTH_W-1:0]    dsel;
    outcome_t              osel;

    assign hidx        = LOOP_W'(head.region);
    assign pidx        = LOOP_W'(pix_reg.region);
    assign span        = (cfg.max_dist > cfg.min_dist) ? cfg.max_dist - cfg.min_dist : '0;
    assign last_region = walk_reg == LOOP_W'(NUM_REGIONS - 1);
    assign out_load    = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // percentile search on the registered read data of the bin walk
    assign cum_next = cum_reg + CUM_W'(mem_rdata_reg);
    assign bin_live = rd_valid_reg && !found_reg && KC_W'(rd_k_reg) < KC_W'(cfg.bin_num);
    assign hit      = {cum_next, {FRAC_W{1'b0}}} > CMP_W'(lim_reg);

    always_comb
    begin
        if (few_reg)
        begin
            dsel = cfg.max_dist;
            osel = OUTC_FEW;
        end
        else if (found_reg)
        begin
            dsel = cfg.min_dist + DEPTH_W'(div_quo);
            osel = OUTC_FOUND;
        end
        else
        begin
            dsel = last_dep_reg[walk_reg];
            osel = OUTC_KEPT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        div_num    = mul_reg;
        div_den    = span;
        mem_we     = 1'b0;
        mem_addr   = {walk_reg, k_reg};
        mem_wdata  = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we   = 1'b1;
                mem_addr = sweep_reg;
                if (sweep_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head.binned)
                    begin
                        state_next = ST_PMUL;
                    end
                    else if (head.frame_end)
                    begin
                        state_next = ST_REG;
                    end
                end
            end
            ST_PMUL:
            begin
                state_next = ST_PDIV;
            end
            ST_PDIV:
            begin
                div_start  = 1'b1;
                state_next = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_PRD;
                end
            end
            ST_PRD:
            begin
                mem_addr   = {pidx, bin_reg};
                state_next = ST_PWR;
            end
            ST_PWR:
            begin
                mem_we     = 1'b1;
                mem_addr   = {pidx, bin_reg};
                mem_wdata  = (mem_rdata_reg == '1) ? mem_rdata_reg : mem_rdata_reg + 1'b1;
                state_next = pix_reg.frame_end ? ST_REG : ST_IDLE;
            end
            ST_REG:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // every bin of the region is read and zeroed, used or not
                mem_we = 1'b1;
                if (k_reg == BIDX_W'(MAX_BINS - 1))
                begin
                    state_next = ST_WTAIL;
                end
            end
            ST_WTAIL:
            begin
                state_next = ST_DMUL;
            end
            ST_DMUL:
            begin
                state_next = (found_reg && !few_reg) ? ST_DDIV : ST_OUT;
            end
            ST_DDIV:
            begin
                div_start  = 1'b1;
                div_den    = DEPTH_W'(cfg.bin_num);
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = last_region ? ST_IDLE : ST_REG;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rhp_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEPTH_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            walk_reg      <= '0;
            k_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            few_reg       <= 1'b0;
            cum_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGIONS; i++)
            begin
                pix_cnt_reg[i]  <= '0;
                val_cnt_reg[i]  <= '0;
                last_dep_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= state_reg == ST_WALK;
            rd_k_reg     <= k_reg;

            if (bin_live)
            begin
                cum_reg <= cum_next;
                if (hit)
                begin
                    found_reg <= 1'b1;
                    fk_reg    <= rd_k_reg;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        pix_reg  <= head;
                        walk_reg <= '0;
                        if (head.counted && pix_cnt_reg[hidx] != '1)
                        begin
                            pix_cnt_reg[hidx] <= pix_cnt_reg[hidx] + 1'b1;
                        end
                        if (head.valid && val_cnt_reg[hidx] != '1)
                        begin
                            val_cnt_reg[hidx] <= val_cnt_reg[hidx] + 1'b1;
                        end
                    end
                end
                ST_PMUL:
                begin
                    mul_reg <= NUM_W'(pix_reg.offset) * NUM_W'(cfg.bin_num);
                end
                ST_PWAIT:
                begin
                    if (div_done)
                    begin
                        bin_reg <= (div_quo >= NUM_W'(cfg.bin_num)) ?
                                   BIDX_W'(cfg.bin_num - 1'b1) : BIDX_W'(div_quo);
                    end
                end
                ST_REG:
                begin
                    thr_prod_reg <= PROD_W'(cfg.thresh) * PROD_W'(pix_cnt_reg[walk_reg]);
                    lim_reg      <= PROD_W'(cfg.ignore) * PROD_W'(pix_cnt_reg[walk_reg]);
                    cum_reg      <= '0;
                    found_reg    <= 1'b0;
                    k_reg        <= '0;
                end
                ST_CMP:
                begin
                    few_reg <= {val_cnt_reg[walk_reg], {FRAC_W{1'b0}}} < thr_prod_reg;
                end
                ST_WALK:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                ST_DMUL:
                begin
                    mul_reg <= NUM_W'(fk_reg) * NUM_W'(span);
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        idx_reg                <= REGION_W'(walk_reg);
                        depth_reg              <= dsel;
                        outc_reg               <= osel;
                        last_reg               <= last_region;
                        last_dep_reg[walk_reg] <= dsel;
                        pix_cnt_reg[walk_reg]  <= '0;
                        val_cnt_reg[walk_reg]  <= '0;
                        if (!last_region)
                        begin
                            walk_reg <= walk_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.pop       = pop;
    assign stat.init_busy = state_reg == ST_INIT;

    assign out_valid    = out_valid_reg;
    assign region_index = idx_reg;
    assign region_depth = depth_reg;
    assign outcome      = outc_reg;
    assign last         = last_reg;

endmodule
